// ===== hdl/cld_pkg.sv =====
// shared types, codes and sizes for the console line discipline
package cld_pkg;

    localparam int TX_DEPTH    = 32;
    localparam int LINE_DEPTH  = 32;
    localparam int TX_AW       = $clog2(TX_DEPTH);
    localparam int TX_CW       = $clog2(TX_DEPTH + 1);
    localparam int LN_AW       = $clog2(LINE_DEPTH);
    localparam int LN_CW       = $clog2(LINE_DEPTH + 1);
    localparam int LEN_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] REQ_RX    = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TXRDY = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_LEND = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    typedef enum logic [1:0] {
        OP_RX,
        OP_WRITE,
        OP_TXRDY
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       is_lf;
        logic       start;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data;
        logic       write_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data_res;
        logic [LEN_W-1:0] line_length;
        logic             last;
    } t_out_item;

endpackage

// ===== hdl/cld_front.sv =====
// request decode and the short command queue in front of the engine
module cld_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_console_enabled,
    input  logic              i_in_valid,
    input  cld_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    output logic              o_cmd_valid,
    output cld_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    cld_pkg::t_cmd            r_q [cld_pkg::QUEUE_DEPTH];
    logic [cld_pkg::Q_AW-1:0] r_wr_ptr;
    logic [cld_pkg::Q_AW-1:0] r_rd_ptr;
    logic [cld_pkg::Q_CW-1:0] r_cnt;

    cld_pkg::t_cmd dec_cmd;
    logic          dec_keep;
    logic          push;
    logic          pop;

    always_comb begin
        dec_cmd  = '0;
        dec_keep = 1'b0;
        dec_cmd.ch = i_in_item.data;
        unique case (i_in_item.req_type)
            cld_pkg::REQ_RX: begin
                // receive side folds CR into LF; ignored while nobody owns the console
                dec_keep      = i_console_enabled;
                dec_cmd.op    = cld_pkg::OP_RX;
                dec_cmd.start = 1'b1;
                if (i_in_item.data == cld_pkg::CH_CR) begin
                    dec_cmd.ch = cld_pkg::CH_LF;
                end
            end
            cld_pkg::REQ_WRITE: begin
                dec_keep      = 1'b1;
                dec_cmd.op    = cld_pkg::OP_WRITE;
                dec_cmd.start = i_in_item.write_last;
            end
            cld_pkg::REQ_TXRDY: begin
                dec_keep   = 1'b1;
                dec_cmd.op = cld_pkg::OP_TXRDY;
            end
            default: begin
                dec_keep = 1'b0;
            end
        endcase
        dec_cmd.is_lf = (dec_cmd.ch == cld_pkg::CH_LF);
    end

    assign o_in_stall  = (r_cnt == cld_pkg::Q_CW'(cld_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall && dec_keep;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == cld_pkg::Q_AW'(cld_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == cld_pkg::Q_AW'(cld_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

// ===== hdl/cld_back.sv =====
// command engine: transmit queue, line store and result sequencing
module cld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_console_enabled,
    input  logic               i_cmd_valid,
    input  cld_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    output cld_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_ENQ_LF,
        S_START,
        S_TXOUT,
        S_LINE,
        S_DRAIN,
        S_LEND,
        S_TXRDY,
        S_DONE
    } t_state;

    t_state                      r_state;
    cld_pkg::t_cmd               r_cmd;
    logic [cld_pkg::TX_AW-1:0]   r_tx_head;
    logic [cld_pkg::TX_CW-1:0]   r_tx_count;
    logic                        r_tx_busy;
    logic [cld_pkg::LN_CW-1:0]   r_line_count;
    logic [cld_pkg::LN_CW-1:0]   r_rd_idx;
    logic                        r_hold_valid;
    cld_pkg::t_out_item          r_hold;
    logic                        r_out_valid;
    cld_pkg::t_out_item          r_out;

    logic [7:0] tx_mem [cld_pkg::TX_DEPTH];
    logic [7:0] ln_mem [cld_pkg::LINE_DEPTH];
    logic [7:0] r_tx_rd;
    logic [7:0] r_ln_rd;

    logic                      out_free;
    logic                      go;
    logic [cld_pkg::TX_CW:0]   tail_sum;
    logic [cld_pkg::TX_CW:0]   tail_wrap;
    logic [cld_pkg::TX_AW-1:0] tx_tail;
    logic [cld_pkg::TX_CW:0]   need_sum;
    logic                      tx_full;
    logic [cld_pkg::TX_AW-1:0] head_nxt;
    logic                      can_start;
    logic                      tx_we;
    logic [7:0]                tx_wdata;
    logic                      tx_re;
    logic                      ln_we;
    logic                      ln_re;
    logic [cld_pkg::LN_AW-1:0] ln_raddr;
    logic                      emit;
    cld_pkg::t_out_item        emit_item;
    logic                      flush;
    t_state                    state_nxt;

    // the newest result waits in the hold slot until we know whether it is the last
    assign out_free = !r_out_valid || !i_out_stall;
    assign go       = !r_hold_valid || out_free;

    assign tail_sum  = (cld_pkg::TX_CW + 1)'(r_tx_head) + (cld_pkg::TX_CW + 1)'(r_tx_count);
    assign tail_wrap = (tail_sum >= (cld_pkg::TX_CW + 1)'(cld_pkg::TX_DEPTH)) ?
                       tail_sum - (cld_pkg::TX_CW + 1)'(cld_pkg::TX_DEPTH) : tail_sum;
    assign tx_tail   = tail_wrap[cld_pkg::TX_AW-1:0];
    // a CR LF pair goes in whole or not at all
    assign need_sum  = (cld_pkg::TX_CW + 1)'(r_tx_count) +
                       (r_cmd.is_lf ? (cld_pkg::TX_CW + 1)'(2) : (cld_pkg::TX_CW + 1)'(1));
    assign tx_full   = need_sum > (cld_pkg::TX_CW + 1)'(cld_pkg::TX_DEPTH);
    assign head_nxt  = (r_tx_head == cld_pkg::TX_AW'(cld_pkg::TX_DEPTH - 1)) ?
                       '0 : r_tx_head + 1'b1;
    assign can_start = (r_tx_count != '0) && !r_tx_busy && i_console_enabled;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        tx_we     = 1'b0;
        tx_wdata  = r_cmd.ch;
        tx_re     = 1'b0;
        ln_we     = 1'b0;
        ln_re     = 1'b0;
        ln_raddr  = r_rd_idx[cld_pkg::LN_AW-1:0];
        emit      = 1'b0;
        emit_item = '0;
        flush     = 1'b0;
        state_nxt = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    state_nxt = (i_cmd.op == cld_pkg::OP_TXRDY) ? S_TXRDY : S_ENQ;
                end
            end
            S_ENQ: begin
                if (tx_full) begin
                    emit           = 1'b1;
                    emit_item.kind = cld_pkg::KIND_DROP;
                    state_nxt      = S_START;
                end else begin
                    tx_we     = 1'b1;
                    tx_wdata  = r_cmd.is_lf ? cld_pkg::CH_CR : r_cmd.ch;
                    state_nxt = r_cmd.is_lf ? S_ENQ_LF : S_START;
                end
            end
            S_ENQ_LF: begin
                tx_we     = 1'b1;
                tx_wdata  = cld_pkg::CH_LF;
                state_nxt = S_START;
            end
            S_START: begin
                if (r_cmd.start && can_start) begin
                    tx_re     = 1'b1;
                    state_nxt = S_TXOUT;
                end else begin
                    state_nxt = (r_cmd.op == cld_pkg::OP_RX) ? S_LINE : S_DONE;
                end
            end
            S_TXOUT: begin
                emit               = 1'b1;
                emit_item.kind     = cld_pkg::KIND_TX;
                emit_item.data_res = r_tx_rd;
                state_nxt          = (r_cmd.op == cld_pkg::OP_RX) ? S_LINE : S_DONE;
            end
            S_LINE: begin
                if (!r_cmd.is_lf) begin
                    if (r_line_count < cld_pkg::LN_CW'(cld_pkg::LINE_DEPTH)) begin
                        ln_we = 1'b1;
                    end else begin
                        emit           = 1'b1;
                        emit_item.kind = cld_pkg::KIND_DROP;
                    end
                    state_nxt = S_DONE;
                end else if (r_line_count != '0) begin
                    ln_re     = 1'b1;
                    ln_raddr  = '0;
                    state_nxt = S_DRAIN;
                end else begin
                    state_nxt = S_LEND;
                end
            end
            S_DRAIN: begin
                // one line byte out per cycle while the next one is read, unless the output holds the engine
                emit               = 1'b1;
                emit_item.kind     = cld_pkg::KIND_LINE;
                emit_item.data_res = r_ln_rd;
                if (r_rd_idx < r_line_count) begin
                    ln_re = 1'b1;
                end else begin
                    state_nxt = S_LEND;
                end
            end
            S_LEND: begin
                emit                  = 1'b1;
                emit_item.kind        = cld_pkg::KIND_LEND;
                emit_item.line_length = cld_pkg::LEN_W'(r_line_count);
                state_nxt             = S_DONE;
            end
            S_TXRDY: begin
                if (r_tx_busy && i_console_enabled && (r_tx_count != '0)) begin
                    tx_re     = 1'b1;
                    state_nxt = S_TXOUT;
                end else begin
                    state_nxt = S_DONE;
                end
            end
            S_DONE: begin
                flush     = r_hold_valid;
                state_nxt = S_IDLE;
            end
            default: begin
                state_nxt = S_IDLE;
            end
        endcase
        if (!go) begin
            tx_we     = 1'b0;
            tx_re     = 1'b0;
            ln_we     = 1'b0;
            ln_re     = 1'b0;
            emit      = 1'b0;
            flush     = 1'b0;
            state_nxt = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tx_head    <= '0;
            r_tx_count   <= '0;
            r_tx_busy    <= 1'b0;
            r_line_count <= '0;
            r_rd_idx     <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= state_nxt;
            if (o_cmd_pop) begin
                r_cmd <= i_cmd;
            end
            if (tx_we) begin
                r_tx_count <= r_tx_count + 1'b1;
            end
            if (tx_re) begin
                r_tx_head  <= head_nxt;
                r_tx_count <= r_tx_count - 1'b1;
                r_tx_busy  <= 1'b1;
            end
            if (go && r_state == S_TXRDY && r_tx_busy &&
                (!i_console_enabled || r_tx_count == '0)) begin
                r_tx_busy <= 1'b0;
            end
            if (ln_we) begin
                r_line_count <= r_line_count + 1'b1;
            end
            if (ln_re) begin
                r_rd_idx <= (cld_pkg::LN_CW)'(ln_raddr) + 1'b1;
            end
            if (go && r_state == S_LEND) begin
                r_line_count <= '0;
            end
            // a new result takes the output register in the cycle the old one leaves
            if (flush || (emit && r_hold_valid)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                if (r_hold_valid) begin
                    r_out <= r_hold;
                end
                r_hold       <= emit_item;
                r_hold_valid <= 1'b1;
            end
            if (flush) begin
                r_out        <= '{kind: r_hold.kind, data_res: r_hold.data_res,
                                  line_length: r_hold.line_length, last: 1'b1};
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_mem[tx_tail] <= tx_wdata;
        end
        if (tx_re) begin
            r_tx_rd <= tx_mem[r_tx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ln_we) begin
            ln_mem[r_line_count[cld_pkg::LN_AW-1:0]] <= r_cmd.ch;
        end
        if (ln_re) begin
            r_ln_rd <= ln_mem[ln_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_tx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= cld_pkg::TX_CW'(cld_pkg::TX_DEPTH))
        else $error("transmit queue count beyond depth");

    a_line_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= cld_pkg::LN_CW'(cld_pkg::LINE_DEPTH))
        else $error("line store count beyond depth");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_valid)
        else $error("result left in hold slot after request finished");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> r_line_count != '0)
        else $error("draining an empty line");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_tx_busy) |-> $past(r_state) == S_TXRDY)
        else $error("transmitter went idle outside a ready event");

endmodule

// ===== hdl/console_line_discipline_core.sv =====
// top level of the console line discipline: enable register, front decode and engine
// Requests are decoded on entry (CR folds to LF on receive; unused codes are always dropped,
// receive bytes while the console is not enabled) and wait in a two-deep command
// queue, so the input side keeps taking requests while the engine works until that queue
// is full. The engine handles one request at a time and produces at most one result per
// cycle: a transmitter-ready event may send one queued byte, a host write byte is queued
// (an LF as CR LF) and may start sending, a received ordinary byte is echoed and added
// to the line, and a received line end is echoed and then gives out the buffered bytes
// of a line of up to 32 bytes, the line store giving one byte per read.
// Results leave through a registered output and stall the engine only when that
// register is still full. The enable register must only be written with the block idle.
module console_line_discipline_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  cld_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output cld_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic          r_console_enabled;
    logic          cmd_valid;
    cld_pkg::t_cmd cmd;
    logic          cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_console_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            r_console_enabled <= i_cfg_wdata;
        end
    end

    cld_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_console_enabled (r_console_enabled),
        .i_in_valid        (i_in_valid),
        .i_in_item         (i_in_item),
        .o_in_stall        (o_in_stall),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_pop         (cmd_pop)
    );

    cld_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_console_enabled (r_console_enabled),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .o_out_valid       (o_out_valid),
        .o_out_item        (o_out_item),
        .i_out_stall       (i_out_stall)
    );

endmodule

// ===== sim/cld_console_sb_pkg.sv =====
// scoreboard for the console line discipline: echo, line assembly and transmit pacing
package cld_console_sb_pkg;

    import cld_pkg::*;

    class console_scoreboard;

        logic [7:0]  tx_ring [TX_DEPTH];
        logic [TX_AW-1:0] tx_head;
        int          tx_fill;
        bit          tx_active;
        logic [7:0]  line_buf [LINE_DEPTH];
        int          line_fill;
        bit          console_on;
        t_out_item   batch [$];
        t_out_item   due_output [$];
        int          failures;

        function new();
            tx_head    = '0;
            tx_fill    = 0;
            tx_active  = 1'b0;
            line_fill  = 0;
            console_on = 1'b0;
            failures   = 0;
        endfunction

        function void set_enable(bit on);
            console_on = on;
        endfunction

        function int outstanding();
            return due_output.size();
        endfunction

        function void add_result(logic [1:0] kind, logic [7:0] ch, int len);
            t_out_item r;
            r.kind        = kind;
            r.data_res    = ch;
            r.line_length = LEN_W'(len);
            r.last        = 1'b0;
            batch.push_back(r);
        endfunction

        // a CR LF pair goes in whole or not at all
        function void queue_char(logic [7:0] ch);
            int need;
            need = (ch == CH_LF) ? 2 : 1;
            if (tx_fill + need > TX_DEPTH) begin
                add_result(KIND_DROP, 8'h00, 0);
                return;
            end
            if (ch == CH_LF) begin
                tx_ring[TX_AW'(tx_head + tx_fill)] = CH_CR;
                tx_fill++;
            end
            tx_ring[TX_AW'(tx_head + tx_fill)] = ch;
            tx_fill++;
        endfunction

        function void pop_tx_byte();
            add_result(KIND_TX, tx_ring[tx_head], 0);
            tx_head = tx_head + 1'b1;
            tx_fill--;
        endfunction

        function void kick_tx();
            if (tx_fill != 0 && !tx_active && console_on) begin
                tx_active = 1'b1;
                pop_tx_byte();
            end
        endfunction

        function void note_request(t_in_item req);
            logic [7:0] ch;
            int i;
            ch = req.data;
            batch.delete();
            case (req.req_type)
                REQ_RX: begin
                    if (console_on) begin
                        if (ch == CH_CR) ch = CH_LF;
                        queue_char(ch);
                        kick_tx();
                        if (ch != CH_LF) begin
                            if (line_fill < LINE_DEPTH) begin
                                line_buf[line_fill] = ch;
                                line_fill++;
                            end else begin
                                add_result(KIND_DROP, 8'h00, 0);
                            end
                        end else begin
                            for (i = 0; i < line_fill; i++)
                                add_result(KIND_LINE, line_buf[i], 0);
                            add_result(KIND_LEND, 8'h00, line_fill);
                            line_fill = 0;
                        end
                    end
                end
                REQ_WRITE: begin
                    queue_char(ch);
                    if (req.write_last) kick_tx();
                end
                REQ_TXRDY: begin
                    if (tx_active) begin
                        if (!console_on || tx_fill == 0) tx_active = 1'b0;
                        else pop_tx_byte();
                    end
                end
                default: ;
            endcase
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            foreach (batch[k]) due_output.push_back(batch[k]);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_output.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: kind %0d data %02h len %0d last %0b",
                             got.kind, got.data_res, got.line_length, got.last);
                return;
            end
            want = due_output.pop_front();
            if (got.kind !== want.kind || got.data_res !== want.data_res ||
                got.line_length !== want.line_length || got.last !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected kind %0d data %02h len %0d last %0b, %s",
                             want.kind, want.data_res, want.line_length, want.last,
                             $sformatf("got kind %0d data %02h len %0d last %0b",
                                       got.kind, got.data_res, got.line_length, got.last));
            end
        endfunction

    endclass

endpackage

// ===== sim/tb_top.sv =====
// top of the console line discipline testbench: clock, reset, drivers and run control
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cld_pkg::*;
    import cld_console_sb_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 50000;

    typedef enum { MIX_NORMAL, MIX_FLOOD, MIX_OFFLINE } t_mix;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall = 1'b0;

    console_scoreboard board = new();
    bit gaps_on    = 1'b1;
    bit console_on = 1'b0;
    int live_items = 0;

    console_line_discipline_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_item);
    end

    task automatic send_request(logic [1:0] req, logic [7:0] ch, logic wlast);
        t_in_item it;
        it.req_type   = req;
        it.data       = ch;
        it.write_last = wlast;
        while (gaps_on && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(it);
        if (req != REQ_UNUSED && !(req == REQ_RX && !console_on)) live_items++;
    endtask

    // wait for every expected result, then for the engine to finish silent requests
    task automatic drain_results();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (board.outstanding() > 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_console(bit on);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_enable(on);
        console_on = on;
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == CH_CR || c == CH_LF) c = 8'h20;
        return c;
    endfunction

    task automatic send_line(int len, bit terminate);
        int i;
        for (i = 0; i < len; i++) send_request(REQ_RX, text_char(), 1'($urandom_range(1)));
        if (terminate)
            send_request(REQ_RX, $urandom_range(1) ? CH_CR : CH_LF, 1'($urandom_range(1)));
    endtask

    task automatic send_write(int len);
        int i;
        logic [7:0] c;
        for (i = 0; i < len; i++) begin
            c = ($urandom_range(9) == 0) ? CH_LF : 8'($urandom_range(255));
            send_request(REQ_WRITE, c, i == len - 1);
        end
    endtask

    task automatic send_ready(int n);
        repeat (n) send_request(REQ_TXRDY, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic send_noise();
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic run_traffic(int target, t_mix mix);
        int start;
        int r;
        start = live_items;
        while (live_items - start < target) begin
            r = $urandom_range(99);
            case (mix)
                MIX_NORMAL: begin
                    if (r < 35)      send_line($urandom_range(8), 1'b1);
                    else if (r < 65) send_write($urandom_range(4, 1));
                    else if (r < 90) send_ready($urandom_range(4, 1));
                    else             send_noise();
                end
                MIX_FLOOD: begin
                    // long lines and few ready events push both stores past full
                    if (r < 40)      send_line($urandom_range(40, 20), 1'($urandom_range(1)));
                    else if (r < 75) send_write($urandom_range(8, 3));
                    else if (r < 85) send_ready(1);
                    else             send_noise();
                end
                default: begin
                    if (r < 50)      send_write($urandom_range(6, 1));
                    else if (r < 80) send_ready($urandom_range(3, 1));
                    else if (r < 90) send_line($urandom_range(3), 1'b1);
                    else             send_noise();
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // console not owned: writes queue without sending, receive ignored
        send_request(REQ_WRITE, 8'h41, 1'b0);
        send_request(REQ_WRITE, CH_LF, 1'b1);
        send_request(REQ_RX, 8'h78, 1'b0);
        send_request(REQ_TXRDY, 8'h00, 1'b0);
        send_request(REQ_UNUSED, 8'hFF, 1'b1);
        drain_results();
        set_console(1'b1);

        send_request(REQ_WRITE, 8'h00, 1'b1);
        send_ready(5);
        send_request(REQ_RX, 8'hFF, 1'b1);
        send_request(REQ_RX, 8'h00, 1'b0);
        send_request(REQ_RX, CH_CR, 1'b0);
        send_request(REQ_RX, CH_LF, 1'b1);
        send_ready(6);
        send_request(REQ_RX, 8'h71, 1'b0);
        drain_results();
        // transmitter still busy when ownership is lost
        set_console(1'b0);
        send_request(REQ_TXRDY, 8'hA5, 1'b1);
        send_request(REQ_WRITE, 8'h7A, 1'b1);
        drain_results();
        set_console(1'b1);

        run_traffic(20, MIX_NORMAL);
        drain_results();
        run_traffic(25, MIX_FLOOD);
        drain_results();
        set_console(1'b0);
        run_traffic(15, MIX_OFFLINE);
        drain_results();
        set_console(1'b1);
        gaps_on = 1'b0;
        run_traffic(20, MIX_NORMAL);
        gaps_on = 1'b1;
        drain_results();

        if (board.failures == 0 && board.outstanding() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
